// File: rtl/uoc_pkg.sv
// ----------------------------------------------------------------------------
// uoc_pkg
// Shared widths, constants and controller/datapath handshake types for the
// ultrasonic obstacle confirm core.
// ----------------------------------------------------------------------------
package uoc_pkg;

    // field widths
    localparam int ECHO_W     = 15;
    localparam int NOW_W      = 32;
    localparam int DIST_W     = 18;
    localparam int CNT_W      = 4;
    localparam int THR_W      = 18;
    localparam int COOL_W     = 16;

    // stream word layout
    localparam int IN_TDATA_W  = 48;   // echo_us, now_ms, zero fill
    localparam int OUT_TDATA_W = 24;   // distance_q8, hits_now, zero fill
    localparam int OUT_TUSER_W = 5;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THR = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 8'd3;

    localparam logic [CNT_W-1:0]  SAMPLES_RST  = 4'd3;
    localparam logic [THR_W-1:0]  NEAR_THR_RST = 18'd5120;
    localparam logic [CNT_W-1:0]  CONFIRM_RST  = 4'd2;
    localparam logic [COOL_W-1:0] COOLDOWN_RST = 16'd2000;

    // arithmetic
    localparam logic [ECHO_W-1:0] MAX_ECHO_US = 15'd30000;
    localparam logic [DIST_W-1:0] DIST_MAX    = 18'h3FFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX     = 4'hF;
    localparam int MUL_W      = 13;
    localparam logic [MUL_W-1:0]  DIST_MUL    = 13'd4496;
    localparam int DIST_SHIFT = 10;
    localparam int PROD_W     = DIST_W + MUL_W;
    localparam int DRAW_W     = PROD_W - DIST_SHIFT;

    // bit-serial divider: one quotient bit per step
    localparam int DIV_STEPS  = DIST_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;      // capture input word
        logic eval;      // cooldown/enable checks, accumulate, start divide
        logic div_step;  // one restoring divide step
        logic mul;       // register avg * scale
        logic fin;       // hit debounce and result write
    } uoc_cmd_t;

    typedef struct packed {
        logic need_div;  // group completed with at least one valid echo
        logic div_last;  // final divide step this cycle
        logic out_free;  // result register can take a new word
    } uoc_sts_t;

endpackage

// File: rtl/uoc_ctrl.sv
// ----------------------------------------------------------------------------
// uoc_ctrl
// Sequencer: accept, evaluate, optional divide and scale, commit result.
// ----------------------------------------------------------------------------
module uoc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  uoc_pkg::uoc_sts_t sts,
    output uoc_pkg::uoc_cmd_t cmd
);
    import uoc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t state_reg;

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        cmd.load     = s_ready && s_valid;
        cmd.eval     = (state_reg == ST_EVAL);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.fin      = (state_reg == ST_FIN) && sts.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    state_reg <= sts.need_div ? ST_DIV : ST_FIN;
                end
                ST_DIV: begin
                    if (sts.div_last) state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (sts.out_free) state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/uoc_dp.sv
// ----------------------------------------------------------------------------
// uoc_dp
// Datapath: config registers, group accumulator, bit-serial divider,
// distance scaling, hit debounce, cooldown and the result register.
// ----------------------------------------------------------------------------
module uoc_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  uoc_pkg::uoc_cmd_t                    cmd,
    output uoc_pkg::uoc_sts_t                    sts,
    input  logic [uoc_pkg::ECHO_W-1:0]           echo_us,
    input  logic                                 monitor_enable,
    input  logic [uoc_pkg::NOW_W-1:0]            now_ms,
    input  logic                                 cfg_we,
    input  logic [uoc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [uoc_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [uoc_pkg::OUT_TDATA_W-1:0]      m_data,
    output logic [uoc_pkg::OUT_TUSER_W-1:0]      m_user
);
    import uoc_pkg::*;

    // configuration
    logic [CNT_W-1:0]  spr_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [CNT_W-1:0]  conf_reg;
    logic [COOL_W-1:0] cool_reg;

    // architectural state
    logic [CNT_W-1:0]  idx_reg;
    logic [DIST_W-1:0] sum_reg;
    logic [CNT_W-1:0]  ve_reg;
    logic [CNT_W-1:0]  hit_reg;
    logic [NOW_W-1:0]  cool_end_reg;

    // captured item and per-item flags
    logic [ECHO_W-1:0] echo_reg;
    logic              en_reg;
    logic [NOW_W-1:0]  now_reg;
    logic              done_reg;
    logic              valid_reg;
    logic              skip_reg;

    // divider and scaler
    logic [DIST_W-1:0]    quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dsor_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [PROD_W-1:0]    prod_reg;

    // result word
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic [OUT_TUSER_W-1:0] m_user_reg;

    // evaluate-stage logic
    logic [NOW_W-1:0]  cool_diff;
    logic              in_cool;
    logic              active;
    logic [CNT_W-1:0]  group;
    logic              echo_ok;
    logic [DIST_W:0]   sum_wide;
    logic [DIST_W-1:0] sum_upd;
    logic [CNT_W-1:0]  ve_upd;
    logic [CNT_W-1:0]  idx_upd;
    logic              grp_done;
    logic              eval_done;

    // divide step
    logic [CNT_W:0]    div_t;
    logic [CNT_W:0]    div_d;
    logic              div_ge;

    // finish-stage logic
    logic [DRAW_W-1:0] dist_raw;
    logic [DIST_W-1:0] dist_val;
    logic              near;
    logic [CNT_W-1:0]  hit_inc;
    logic              obst;
    logic [CNT_W-1:0]  hit_fin;

    always_comb begin
        cool_diff = now_reg - cool_end_reg;
        in_cool   = cool_diff[NOW_W-1];
        active    = !in_cool && en_reg;
        group     = (spr_reg == '0) ? CNT_W'(1) : spr_reg;
        echo_ok   = (echo_reg != '0) && (echo_reg <= MAX_ECHO_US);
        sum_wide  = {1'b0, sum_reg} + (DIST_W+1)'(echo_reg);
        if (!echo_ok) begin
            sum_upd = sum_reg;
        end else if (sum_wide > {1'b0, DIST_MAX}) begin
            sum_upd = DIST_MAX;
        end else begin
            sum_upd = sum_wide[DIST_W-1:0];
        end
        ve_upd    = (echo_ok && ve_reg != CNT_MAX) ? ve_reg + CNT_W'(1) : ve_reg;
        idx_upd   = idx_reg + CNT_W'(1);
        grp_done  = (idx_upd >= group) || (idx_upd == '0);
        eval_done = active && grp_done;

        div_t  = {rem_reg, quo_reg[DIST_W-1]};
        div_d  = div_t - {1'b0, dsor_reg};
        div_ge = (div_t >= {1'b0, dsor_reg});

        dist_raw = prod_reg[PROD_W-1:DIST_SHIFT];
        if (!valid_reg) begin
            dist_val = '0;
        end else if (|dist_raw[DRAW_W-1:DIST_W]) begin
            dist_val = DIST_MAX;
        end else begin
            dist_val = dist_raw[DIST_W-1:0];
        end
        near    = valid_reg && (dist_val <= thr_reg);
        hit_inc = (hit_reg == CNT_MAX) ? hit_reg : hit_reg + CNT_W'(1);
        obst    = near && (hit_inc >= conf_reg);
        if (near) begin
            hit_fin = obst ? '0 : hit_inc;
        end else if (done_reg) begin
            hit_fin = '0;
        end else begin
            hit_fin = hit_reg;
        end

        sts.need_div = eval_done && (ve_upd != '0);
        sts.div_last = (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        sts.out_free = !m_valid_reg || m_ready;
    end

    // configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spr_reg      <= SAMPLES_RST;
            thr_reg      <= NEAR_THR_RST;
            conf_reg     <= CONFIRM_RST;
            cool_reg     <= COOLDOWN_RST;
            idx_reg      <= '0;
            sum_reg      <= '0;
            ve_reg       <= '0;
            hit_reg      <= '0;
            cool_end_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SAMPLES:  spr_reg  <= cfg_data[CNT_W-1:0];
                    REG_NEAR_THR: thr_reg  <= cfg_data[THR_W-1:0];
                    REG_CONFIRM:  conf_reg <= cfg_data[CNT_W-1:0];
                    REG_COOLDOWN: cool_reg <= cfg_data[COOL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.eval && !in_cool) begin
                if (!en_reg) begin
                    hit_reg <= '0;
                    idx_reg <= '0;
                    sum_reg <= '0;
                    ve_reg  <= '0;
                end else if (grp_done) begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                    ve_reg  <= '0;
                end else begin
                    idx_reg <= idx_upd;
                    sum_reg <= sum_upd;
                    ve_reg  <= ve_upd;
                end
            end
            if (cmd.fin) begin
                hit_reg <= hit_fin;
                if (obst) cool_end_reg <= now_reg + NOW_W'(cool_reg);
            end
            if (cmd.fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            echo_reg <= echo_us;
            en_reg   <= monitor_enable;
            now_reg  <= now_ms;
        end
        if (cmd.eval) begin
            done_reg  <= eval_done;
            valid_reg <= eval_done && (ve_upd != '0);
            skip_reg  <= !active;
            quo_reg   <= sum_upd;
            rem_reg   <= '0;
            dsor_reg  <= ve_upd;
            dcnt_reg  <= '0;
        end
        if (cmd.div_step) begin
            quo_reg  <= {quo_reg[DIST_W-2:0], div_ge};
            rem_reg  <= div_ge ? div_d[CNT_W-1:0] : div_t[CNT_W-1:0];
            dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(quo_reg) * PROD_W'(DIST_MUL);
        end
        if (cmd.fin) begin
            if (!valid_reg) prod_reg <= '0;
            m_data_reg <= OUT_TDATA_W'({hit_fin, dist_val});
            m_user_reg <= {skip_reg, obst, near, valid_reg, done_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_user  = m_user_reg;

endmodule

// File: rtl/ultrasonic_obstacle_confirm_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_obstacle_confirm_core
// Averages groups of echo widths into a distance, debounces near readings
// into an obstacle flag and holds off input for a cooldown after a trigger.
// ----------------------------------------------------------------------------
// Sequence: an item is accepted, evaluated and written to the result register;
//   an item that closes a group with a valid echo first passes through the
//   one-bit-per-cycle divider that forms the average, then the scaler.
// Flow: one item in flight; a finished result waits in the output register
//   while the next word is taken, and the next commit stalls until it is taken.
// Reset: aresetn synchronous, active low; registers return to their defaults,
//   group state, hit count and cooldown end clear to zero.
module ultrasonic_obstacle_confirm_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [14:0] echo_us, [46:15] now_ms, [47] zero
    input  logic [uoc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] monitor_enable
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [17:0] distance_q8, [21:18] hits_now, [23:22] zero
    output logic [uoc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] reading_done, [1] reading_valid, [2] near_hit, [3] obstacle, [4] skipped
    output logic [uoc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [uoc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [uoc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import uoc_pkg::*;

    uoc_cmd_t cmd;
    uoc_sts_t sts;

    assign cfg_ready = 1'b1;

    uoc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    uoc_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .echo_us        (s_axis_tdata[ECHO_W-1:0]),
        .monitor_enable (s_axis_tuser),
        .now_ms         (s_axis_tdata[ECHO_W+NOW_W-1:ECHO_W]),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .m_data         (m_axis_tdata),
        .m_user         (m_axis_tuser)
    );

    // an obstacle word closes a near reading and restarts the hit count
    a_obst_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[3]) |->
            (m_axis_tuser[0] && m_axis_tuser[1] && m_axis_tuser[2] &&
             m_axis_tdata[21:18] == 4'd0))
        else $error("obstacle word inconsistent");

    // a skipped item never completes a reading
    a_skip_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[4]) |-> (m_axis_tuser[3:0] == 4'd0))
        else $error("skipped item reports a reading");

    // distance only reported for a valid reading
    a_dist_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[17:0] == 18'd0))
        else $error("distance without valid reading");

    // one item in flight: input closes right after a word is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while busy");

endmodule

// File: verif/ultrasonic_obstacle_confirm_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_obstacle_confirm_core_test
// Streams echo words into the core under random source and sink stalls and
// checks every result word against a cycle-free model of the averaging,
// hit debounce and cooldown logic. The run covers a directed opening and then
// random echo streams under a series of register settings.
// ----------------------------------------------------------------------------
module ultrasonic_obstacle_confirm_core_test;
    import uoc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [ECHO_W-1:0] echo;
        logic              enable;
        logic [NOW_W-1:0]  stamp;
    } echo_word_t;

    typedef struct packed {
        logic              done;
        logic              valid;
        logic [DIST_W-1:0] dist_q8;
        logic              near;
        logic [CNT_W-1:0]  hits;
        logic              obstacle;
        logic              skipped;
    } reading_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ultrasonic_obstacle_confirm_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    // model registers and state
    logic [CNT_W-1:0]  cfg_group   = SAMPLES_RST;
    logic [THR_W-1:0]  cfg_near    = NEAR_THR_RST;
    logic [CNT_W-1:0]  cfg_confirm = CONFIRM_RST;
    logic [COOL_W-1:0] cfg_cool    = COOLDOWN_RST;
    logic [CNT_W-1:0]  grp_idx     = '0;
    logic [DIST_W-1:0] grp_sum     = '0;
    logic [CNT_W-1:0]  grp_valid   = '0;
    logic [CNT_W-1:0]  hit_run     = '0;
    logic [NOW_W-1:0]  hold_until  = '0;

    echo_word_t echo_words[$];
    reading_t   readings_due[$];
    logic       word_taken = 1'b0;
    int         stall_pct = 28;
    int         err_cnt = 0;
    int         cycle_cnt = 0;
    logic [NOW_W-1:0] clock_ms = '0;

    function automatic reading_t range_predict(input logic [ECHO_W-1:0] echo,
                                               input logic enable,
                                               input logic [NOW_W-1:0] stamp);
        reading_t r;
        logic [NOW_W-1:0] since;
        logic [CNT_W-1:0] group;
        logic [DIST_W:0] sum_w;
        logic [DIST_W-1:0] avg;
        logic [31:0] scaled;
        r = '0;
        group = (cfg_group == 0) ? 4'd1 : cfg_group;
        since = stamp - hold_until;
        if (since[NOW_W-1]) begin
            r.skipped = 1'b1;
        end else if (!enable) begin
            r.skipped = 1'b1;
            hit_run = '0;
            grp_idx = '0;
            grp_sum = '0;
            grp_valid = '0;
        end else begin
            if (echo != 0 && echo <= MAX_ECHO_US) begin
                sum_w = grp_sum + echo;
                grp_sum = (sum_w > DIST_MAX) ? DIST_MAX : sum_w[DIST_W-1:0];
                if (grp_valid != CNT_MAX)
                    grp_valid = grp_valid + 1'b1;
            end
            grp_idx = grp_idx + 1'b1;
            if (grp_idx >= group || grp_idx == 0) begin
                r.done = 1'b1;
                if (grp_valid != 0) begin
                    avg = grp_sum / grp_valid;
                    scaled = ({14'd0, avg} * 32'd4496) >> DIST_SHIFT;
                    r.valid = 1'b1;
                    r.dist_q8 = (scaled > DIST_MAX) ? DIST_MAX : scaled[DIST_W-1:0];
                end
                grp_idx = '0;
                grp_sum = '0;
                grp_valid = '0;
                if (r.valid && r.dist_q8 <= cfg_near) begin
                    r.near = 1'b1;
                    if (hit_run != CNT_MAX)
                        hit_run = hit_run + 1'b1;
                    if (hit_run >= cfg_confirm) begin
                        r.obstacle = 1'b1;
                        hit_run = '0;
                        hold_until = stamp + {16'd0, cfg_cool};
                    end
                end else begin
                    hit_run = '0;
                end
            end
        end
        r.hits = hit_run;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input int unsigned got,
                                 input int unsigned want_v);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("mismatch %s: got %0d want %0d (cycle %0d)", field, got, want_v,
                     cycle_cnt);
    endtask

    // source: holds a word until taken, then pops the next one or idles
    always @(negedge aclk) begin
        echo_word_t w;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (echo_words.size() != 0 && $urandom_range(0, 99) >= stall_pct) begin
                w = echo_words.pop_front();
                s_axis_tdata <= {1'b0, w.stamp, w.echo};
                s_axis_tuser <= w.enable;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink back-pressure
    always @(negedge aclk) begin
        m_axis_tready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge aclk) begin
        reading_t want;
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            word_taken <= aresetn && s_axis_tvalid && s_axis_tready;
            if (aresetn && s_axis_tvalid && s_axis_tready)
                readings_due.push_back(range_predict(s_axis_tdata[ECHO_W-1:0], s_axis_tuser,
                                                     s_axis_tdata[ECHO_W+NOW_W-1:ECHO_W]));
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                if (readings_due.size() == 0) begin
                    flag_mismatch("unexpected word", m_axis_tdata, 0);
                end else begin
                    want = readings_due.pop_front();
                    if (m_axis_tuser[0] !== want.done)
                        flag_mismatch("reading_done", m_axis_tuser[0], want.done);
                    if (m_axis_tuser[1] !== want.valid)
                        flag_mismatch("reading_valid", m_axis_tuser[1], want.valid);
                    if (m_axis_tdata[17:0] !== want.dist_q8)
                        flag_mismatch("distance_q8", m_axis_tdata[17:0], want.dist_q8);
                    if (m_axis_tuser[2] !== want.near)
                        flag_mismatch("near_hit", m_axis_tuser[2], want.near);
                    if (m_axis_tdata[21:18] !== want.hits)
                        flag_mismatch("hits_now", m_axis_tdata[21:18], want.hits);
                    if (m_axis_tuser[3] !== want.obstacle)
                        flag_mismatch("obstacle", m_axis_tuser[3], want.obstacle);
                    if (m_axis_tuser[4] !== want.skipped)
                        flag_mismatch("skipped", m_axis_tuser[4], want.skipped);
                end
            end
        end
    end

    task automatic queue_word(input int unsigned echo, input logic enable,
                              input logic [NOW_W-1:0] stamp);
        echo_word_t w;
        w.echo = echo[ECHO_W-1:0];
        w.enable = enable;
        w.stamp = stamp;
        echo_words.push_back(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_SAMPLES:  cfg_group = val[CNT_W-1:0];
            REG_NEAR_THR: cfg_near = val[THR_W-1:0];
            REG_CONFIRM:  cfg_confirm = val[CNT_W-1:0];
            REG_COOLDOWN: cfg_cool = val[COOL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (echo_words.size() != 0 || s_axis_tvalid || readings_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // echo widths biased around the current near limit
    function automatic int unsigned pick_echo();
        int unsigned lim;
        int unsigned r;
        int unsigned v;
        lim = (cfg_near * 1024) / 4496;
        if (lim < 1)
            lim = 1;
        if (lim > 30000)
            lim = 30000;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom_range(1, lim);
        if (r < 65)
            return $urandom_range(1, 30000);
        if (r < 75)
            return 0;
        if (r < 82)
            return $urandom_range(30001, 32767);
        if (r < 90)
            return $urandom_range(0, 32767);
        v = lim + $urandom_range(0, 4);
        return (v > 2) ? v - 2 : 1;
    endfunction

    task automatic queue_random(input int n);
        int r;
        logic [NOW_W-1:0] stamp;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 90)
                clock_ms = clock_ms + $urandom_range(1, 120);
            else if (r < 94)
                clock_ms = clock_ms + $urandom_range(1, 70000);
            stamp = clock_ms;
            if (r == 99)
                stamp = $urandom;   // stray timestamp, base clock untouched
            queue_word(pick_echo(), $urandom_range(0, 99) >= 7, stamp);
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] grp, input logic [CFG_DATA_W-1:0] thr,
                             input logic [CFG_DATA_W-1:0] conf,
                             input logic [CFG_DATA_W-1:0] cool, input int n, input int tail);
        write_reg(REG_SAMPLES, grp);
        write_reg(REG_NEAR_THR, thr);
        write_reg(REG_CONFIRM, conf);
        write_reg(REG_COOLDOWN, cool);
        // start well clear of any cooldown; repeated phases walk the clock past the wrap
        clock_ms = hold_until + 32'h3000_0000;
        queue_random(n);
        if (tail > 0) begin
            clock_ms = clock_ms + 100000;
            queue_word(2000, 1'b0, clock_ms);
            for (int i = 0; i < tail; i++) begin
                clock_ms = clock_ms + 50;
                queue_word(2000, 1'b1, clock_ms);
            end
        end
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // after reset the cooldown end is zero: upper-half timestamps are held off
        queue_word(1000, 1'b1, 32'h8000_0000);
        queue_word(32767, 1'b1, 32'hFFFF_FFFF);
        // timeout, over-range, timeout: group of three with no valid echo
        queue_word(0, 1'b1, 100);
        queue_word(30001, 1'b1, 150);
        queue_word(0, 1'b1, 200);
        // smallest and largest valid widths
        queue_word(1, 1'b1, 250);
        queue_word(30000, 1'b1, 300);
        queue_word(1000, 1'b1, 350);
        // two near readings in a row confirm an obstacle
        queue_word(1000, 1'b1, 400);
        queue_word(1100, 1'b1, 450);
        queue_word(900, 1'b1, 500);
        queue_word(1000, 1'b1, 550);
        queue_word(0, 1'b1, 600);
        queue_word(1100, 1'b1, 650);
        // cooldown runs to 2650
        queue_word(800, 1'b1, 700);
        queue_word(800, 1'b1, 2649);
        queue_word(800, 1'b1, 2650);
        queue_word(800, 1'b0, 2700);
        // just inside the near limit, then monitoring off drops the hit
        queue_word(1166, 1'b1, 2750);
        queue_word(1166, 1'b1, 2800);
        queue_word(1166, 1'b1, 2850);
        queue_word(1166, 1'b0, 3000);
        // just outside the near limit
        queue_word(1167, 1'b1, 3050);
        queue_word(1167, 1'b1, 3100);
        queue_word(1167, 1'b1, 3150);
        wait_drained();

        // widest threshold and longest confirm, no cooldown; ends mid-group
        run_phase(8, 18'h3FFFF, 15, 0, 150, 5);
        // group shrunk below the partial count
        run_phase(2, 5120, 1, 100, 150, 0);
        run_phase(0, 0, 0, 16'hFFFF, 120, 0);
        // long groups saturate the sum and fill the valid count
        run_phase(15, 131712, 3, 500, 150, 0);
        run_phase(1, 8000, 0, 16'hFFFF, 150, 0);
        stall_pct = 0;
        run_phase(SAMPLES_RST, NEAR_THR_RST, CONFIRM_RST, COOLDOWN_RST, 150, 0);
        stall_pct = 28;
        // unmapped indexes must be ignored
        write_reg(8'hFF, 18'($urandom));
        run_phase(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom), 150, 0);
        write_reg(8'($urandom_range(4, 254)), 18'($urandom));
        run_phase(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom), 150, 0);
        run_phase(4, 3000, 4, 1000, 150, 0);

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/uoc_pkg.sv
rtl/uoc_ctrl.sv
rtl/uoc_dp.sv
rtl/ultrasonic_obstacle_confirm_core.sv
verif/ultrasonic_obstacle_confirm_core_test.sv
